### rtl/jsu_pkg.sv
// types, codes and decode helpers for the json string unescaper
`default_nettype none

package jsu_pkg;

    localparam int unsigned MAX_BYTES = 6;

    typedef enum logic [3:0] {
        M_PLAIN    = 4'd0,
        M_ESC      = 4'd1,
        M_HEX      = 4'd2,
        M_HELD     = 4'd3,
        M_HELD_ESC = 4'd4,
        M_HELD_HEX = 4'd5,
        M_SKIP     = 4'd6,
        M_SKIP_ESC = 4'd7,
        M_SKIP_HEX = 4'd8
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BUF_END = 2'd1,
        ST_BAD_ESC = 2'd2,
        ST_BAD_HEX = 2'd3
    } status_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_U = 8'h75;

    localparam logic [15:0] HIGH_SUR_LO = 16'hD800;
    localparam logic [15:0] HIGH_SUR_HI = 16'hDBFF;
    localparam logic [15:0] LOW_SUR_LO = 16'hDC00;
    localparam logic [15:0] LOW_SUR_HI = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] CONT = 8'h80;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_digit_t;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] len;
    } utf8_enc_t;

    function automatic hex_digit_t hex_digit(input logic [7:0] c);
        hex_digit_t d;
        d.ok = 1'b1;
        d.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            d.val = c[3:0] + 4'd9;
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

    // 16-bit code point to 1..3 utf-8 bytes
    function automatic utf8_enc_t encode_cp(input logic [15:0] cp);
        utf8_enc_t e;
        e.b0 = 8'd0;
        e.b1 = 8'd0;
        e.b2 = 8'd0;
        if (cp < 16'h0080) begin
            e.b0 = cp[7:0];
            e.len = 2'd1;
        end else if (cp < 16'h0800) begin
            e.b0 = LEAD2 | {3'b000, cp[10:6]};
            e.b1 = CONT | {2'b00, cp[5:0]};
            e.len = 2'd2;
        end else begin
            e.b0 = LEAD3 | {4'b0000, cp[15:12]};
            e.b1 = CONT | {2'b00, cp[11:6]};
            e.b2 = CONT | {2'b00, cp[5:0]};
            e.len = 2'd3;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

### rtl/jsu_in_if.sv
// input channel: raw string bytes
`default_nettype none

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       buffer_end;

    modport source (output valid, output in_byte, output buffer_end, input ready);
    modport sink (input valid, input in_byte, input buffer_end, output ready);
endinterface

`default_nettype wire

### rtl/jsu_out_if.sv
// output channel: decoded bytes and end-of-string marks
`default_nettype none

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [1:0] status;
    logic [7:0] bad_char;

    modport source (output valid, output out_byte, output byte_valid, output string_done,
                    output status, output bad_char, input ready);
    modport sink (input valid, input out_byte, input byte_valid, input string_done,
                  input status, input bad_char, output ready);
endinterface

`default_nettype wire

### rtl/json_string_unescape_utf8_top.sv
// json string body unescaper with utf-8 output, top level
//
//  channel  dir  payload                                            transaction
//  item     in   in_byte, buffer_end                                valid && ready
//  result   out  out_byte, byte_valid, string_done, status, bad_char valid && ready
//
// each accepted byte is decoded in the accept cycle into a bundle of 0..6 results
// held in the result register; one result leaves it per cycle while result.ready is high.
// a new byte is taken while the bundle is empty or its last result is leaving, so
// bytes giving at most one result flow at one per cycle while result.ready holds.
// async active-low reset returns the decoder to plain text mode with an empty bundle.
`default_nettype none

module json_string_unescape_utf8_top (
    input wire logic clk,
    input wire logic rst_n,
    jsu_in_if.sink   item,
    jsu_out_if.source result
);
    import jsu_pkg::*;

    // decoder state
    mode_t       mode_reg, mode_next;
    logic [15:0] hex_value_reg, hex_value_next;
    logic [2:0]  hex_count_reg, hex_count_next;
    logic [15:0] held_reg, held_next;
    status_t     err_reg, err_next;
    logic [7:0]  letter_reg, letter_next;
    logic [2:0]  skip_reg, skip_next;

    // result bundle
    logic [7:0]  bytes_reg [MAX_BYTES];
    logic [7:0]  bytes_next [MAX_BYTES];
    logic [2:0]  nb_reg, nb_next;
    logic [2:0]  cnt_reg;
    logic [2:0]  idx_reg;
    status_t     st_reg, st_next;
    logic [7:0]  bad_reg, bad_next;
    logic        done_en;

    logic [7:0]  c;
    logic        closing;
    logic        in_fire, out_fire, last_out;

    hex_digit_t  dig;
    logic [15:0] hv_shift;
    logic [2:0]  cnt_inc;
    logic        esc_simple, esc_u;
    logic [7:0]  esc_val;

    logic        pre_held, byte_en, cp_en, pair_en, fin_reset;
    logic [7:0]  main_byte;
    logic [15:0] cp_val;
    status_t     done_st;
    utf8_enc_t   held_enc, main_enc;
    logic [20:0] full;

    assign c = item.in_byte;
    assign closing = (c == CH_QUOTE) &&
                     (mode_reg == M_PLAIN || mode_reg == M_SKIP || mode_reg == M_HELD);

    assign dig = hex_digit(c);
    assign hv_shift = {hex_value_reg[11:0], dig.val};
    assign cnt_inc = hex_count_reg + 3'd1;

    always_comb
    begin
        esc_simple = 1'b1;
        esc_u = 1'b0;
        esc_val = c;
        unique case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: esc_val = c;
            CH_B: esc_val = 8'h08;
            CH_F: esc_val = 8'h0C;
            CH_N: esc_val = 8'h0A;
            CH_R: esc_val = 8'h0D;
            CH_T: esc_val = 8'h09;
            CH_U:
            begin
                esc_simple = 1'b0;
                esc_u = 1'b1;
            end
            default: esc_simple = 1'b0;
        endcase
    end

    // next decoder state and what this byte produces
    always_comb
    begin
        mode_next = mode_reg;
        hex_value_next = hex_value_reg;
        hex_count_next = hex_count_reg;
        held_next = held_reg;
        err_next = err_reg;
        letter_next = letter_reg;
        skip_next = skip_reg;
        pre_held = 1'b0;
        byte_en = 1'b0;
        cp_en = 1'b0;
        pair_en = 1'b0;
        main_byte = c;
        cp_val = hv_shift;
        done_en = 1'b0;
        done_st = ST_OK;
        fin_reset = 1'b0;

        if (item.buffer_end && !closing) begin
            done_en = 1'b1;
            done_st = ST_BUF_END;
            fin_reset = 1'b1;
        end else begin
            unique case (mode_reg)
                M_ESC, M_HELD_ESC:
                begin
                    if (mode_reg == M_HELD_ESC && esc_u) begin
                        hex_value_next = '0;
                        hex_count_next = '0;
                        mode_next = M_HELD_HEX;
                    end else begin
                        if (mode_reg == M_HELD_ESC) begin
                            pre_held = 1'b1;
                            held_next = '0;
                        end
                        mode_next = M_PLAIN;
                        if (esc_simple) begin
                            byte_en = 1'b1;
                            main_byte = esc_val;
                        end else if (esc_u) begin
                            hex_value_next = '0;
                            hex_count_next = '0;
                            mode_next = M_HEX;
                        end else begin
                            err_next = ST_BAD_ESC;
                            letter_next = c;
                            mode_next = M_SKIP;
                        end
                    end
                end
                M_HEX, M_HELD_HEX:
                begin
                    if (!dig.ok) begin
                        pre_held = (mode_reg == M_HELD_HEX);
                        err_next = ST_BAD_HEX;
                        skip_next = 3'd3 - hex_count_reg;
                        hex_count_next = '0;
                        mode_next = (hex_count_reg != 3'd3) ? M_SKIP_HEX : M_SKIP;
                    end else begin
                        hex_value_next = hv_shift;
                        hex_count_next = cnt_inc;
                        if (cnt_inc >= 3'd4) begin
                            hex_count_next = '0;
                            mode_next = M_PLAIN;
                            if (mode_reg == M_HELD_HEX &&
                                hv_shift >= LOW_SUR_LO && hv_shift <= LOW_SUR_HI) begin
                                pair_en = 1'b1;
                                held_next = '0;
                            end else begin
                                if (mode_reg == M_HELD_HEX) begin
                                    pre_held = 1'b1;
                                    held_next = '0;
                                end
                                // a high surrogate waits for its low half
                                if (hv_shift >= HIGH_SUR_LO && hv_shift <= HIGH_SUR_HI) begin
                                    held_next = hv_shift;
                                    mode_next = M_HELD;
                                end else begin
                                    cp_en = 1'b1;
                                end
                            end
                        end
                    end
                end
                M_HELD:
                begin
                    if (c == CH_BSLASH) begin
                        mode_next = M_HELD_ESC;
                    end else begin
                        pre_held = 1'b1;
                        held_next = '0;
                        if (c == CH_QUOTE) begin
                            done_en = 1'b1;
                            done_st = err_reg;
                            fin_reset = 1'b1;
                        end else begin
                            byte_en = 1'b1;
                            mode_next = M_PLAIN;
                        end
                    end
                end
                M_SKIP:
                begin
                    if (c == CH_QUOTE) begin
                        done_en = 1'b1;
                        done_st = err_reg;
                        fin_reset = 1'b1;
                    end else if (c == CH_BSLASH) begin
                        mode_next = M_SKIP_ESC;
                    end
                end
                M_SKIP_ESC:
                begin
                    if (c == CH_U) begin
                        skip_next = 3'd4;
                        mode_next = M_SKIP_HEX;
                    end else begin
                        mode_next = M_SKIP;
                    end
                end
                M_SKIP_HEX:
                begin
                    skip_next = (skip_reg != 3'd0) ? skip_reg - 3'd1 : 3'd0;
                    if (skip_next == 3'd0) begin
                        mode_next = M_SKIP;
                    end
                end
                default:
                begin
                    if (c == CH_QUOTE) begin
                        done_en = 1'b1;
                        done_st = err_reg;
                        fin_reset = 1'b1;
                    end else if (c == CH_BSLASH) begin
                        mode_next = M_ESC;
                    end else begin
                        byte_en = 1'b1;
                        mode_next = M_PLAIN;
                    end
                end
            endcase
        end

        if (fin_reset) begin
            mode_next = M_PLAIN;
            hex_value_next = '0;
            hex_count_next = '0;
            held_next = '0;
            err_next = ST_OK;
            letter_next = '0;
            skip_next = '0;
        end
    end

    // lay out the bytes of this transaction
    assign held_enc = encode_cp(held_reg);
    assign main_enc = encode_cp(cp_val);
    assign full = SUPP_BASE + {1'b0, held_reg[9:0], hv_shift[9:0]};

    always_comb
    begin
        for (int k = 0; k < MAX_BYTES; k++) begin
            bytes_next[k] = 8'd0;
        end
        nb_next = 3'd0;
        if (pair_en) begin
            bytes_next[0] = LEAD4 | {5'b00000, full[20:18]};
            bytes_next[1] = CONT | {2'b00, full[17:12]};
            bytes_next[2] = CONT | {2'b00, full[11:6]};
            bytes_next[3] = CONT | {2'b00, full[5:0]};
            nb_next = 3'd4;
        end else if (pre_held) begin
            bytes_next[0] = held_enc.b0;
            bytes_next[1] = held_enc.b1;
            bytes_next[2] = held_enc.b2;
            nb_next = 3'd3;
            if (byte_en) begin
                bytes_next[3] = main_byte;
                nb_next = 3'd4;
            end else if (cp_en) begin
                bytes_next[3] = main_enc.b0;
                bytes_next[4] = main_enc.b1;
                bytes_next[5] = main_enc.b2;
                nb_next = 3'd3 + {1'b0, main_enc.len};
            end
        end else if (byte_en) begin
            bytes_next[0] = main_byte;
            nb_next = 3'd1;
        end else if (cp_en) begin
            bytes_next[0] = main_enc.b0;
            bytes_next[1] = main_enc.b1;
            bytes_next[2] = main_enc.b2;
            nb_next = {1'b0, main_enc.len};
        end
        st_next = done_en ? done_st : ST_OK;
        bad_next = (done_en && done_st == ST_BAD_ESC) ? letter_reg : 8'd0;
    end

    // handshakes
    assign last_out = (idx_reg + 3'd1 == cnt_reg);
    assign item.ready = (cnt_reg == 3'd0) || (result.ready && last_out);
    assign in_fire = item.valid && item.ready;
    assign out_fire = result.valid && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= M_PLAIN;
            hex_value_reg <= '0;
            hex_count_reg <= '0;
            held_reg <= '0;
            err_reg <= ST_OK;
            letter_reg <= '0;
            skip_reg <= '0;
            cnt_reg <= '0;
            idx_reg <= '0;
        end else begin
            if (in_fire) begin
                mode_reg <= mode_next;
                hex_value_reg <= hex_value_next;
                hex_count_reg <= hex_count_next;
                held_reg <= held_next;
                err_reg <= err_next;
                letter_reg <= letter_next;
                skip_reg <= skip_next;
                cnt_reg <= nb_next + {2'b00, done_en};
                idx_reg <= '0;
            end else if (out_fire) begin
                if (last_out) begin
                    cnt_reg <= '0;
                    idx_reg <= '0;
                end else begin
                    idx_reg <= idx_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            for (int k = 0; k < MAX_BYTES; k++) begin
                bytes_reg[k] <= bytes_next[k];
            end
            nb_reg <= nb_next;
            st_reg <= st_next;
            bad_reg <= bad_next;
        end
    end

    // bytes come first, then the end-of-string mark if there is one
    logic is_byte;
    assign is_byte = (idx_reg < nb_reg);

    assign result.valid = (cnt_reg != 3'd0);
    assign result.out_byte = is_byte ? bytes_reg[idx_reg] : 8'd0;
    assign result.byte_valid = is_byte;
    assign result.string_done = !is_byte;
    assign result.status = is_byte ? 2'd0 : st_reg;
    assign result.bad_char = is_byte ? 8'd0 : bad_reg;

endmodule

`default_nettype wire

### bench/json_string_unescape_utf8_top_tb.sv
// self-checking testbench for the json string unescaper with utf-8 output
`default_nettype none

module json_string_unescape_utf8_top_tb;
    import jsu_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_done;
        logic [1:0] status;
        logic [7:0] bad_char;
    } result_t;

    typedef struct packed {
        logic [7:0] c;
        logic       last;
    } raw_t;

    localparam int RANDOM_ITEMS = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_OFF_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    jsu_in_if  item_ch ();
    jsu_out_if res_ch ();

    json_string_unescape_utf8_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // decoder copy used to predict the result stream
    mode_t       dec_mode;
    logic [15:0] dec_hex;
    logic [2:0]  dec_cnt;
    logic [15:0] dec_held;
    status_t     dec_err;
    logic [7:0]  dec_letter;
    logic [2:0]  dec_skip;
    logic        dec_done;

    result_t expected_q[$];
    raw_t    pending_q[$];
    int      n_errors = 0;
    int      sent_count = 0;

    logic send_gaps = 1'b0;
    int   burst_left = 0;
    logic rx_stalls = 1'b0;
    int   hold_req = 0;

    function automatic void decoder_clear();
        dec_mode = M_PLAIN;
        dec_hex = 16'h0000;
        dec_cnt = 3'd0;
        dec_held = 16'h0000;
        dec_err = ST_OK;
        dec_letter = 8'h00;
        dec_skip = 3'd0;
    endfunction

    function automatic void push_result(logic [7:0] b, logic v, logic d, status_t st,
                                        logic [7:0] bad);
        result_t r;
        r.out_byte = b;
        r.byte_valid = v;
        r.string_done = d;
        r.status = st;
        r.bad_char = bad;
        expected_q.push_back(r);
    endfunction

    function automatic void push_byte(logic [7:0] b);
        push_result(b, 1'b1, 1'b0, ST_OK, 8'h00);
    endfunction

    function automatic void push_done(status_t st);
        push_result(8'h00, 1'b0, 1'b1, st, (st == ST_BAD_ESC) ? dec_letter : 8'h00);
        dec_done = 1'b1;
    endfunction

    function automatic void push_cp(logic [15:0] cp);
        if (cp < 16'h0080)
        begin
            push_byte(cp[7:0]);
        end
        else if (cp < 16'h0800)
        begin
            push_byte(LEAD2 | {3'b000, cp[10:6]});
            push_byte(CONT | {2'b00, cp[5:0]});
        end
        else
        begin
            push_byte(LEAD3 | {4'b0000, cp[15:12]});
            push_byte(CONT | {2'b00, cp[11:6]});
            push_byte(CONT | {2'b00, cp[5:0]});
        end
    endfunction

    // bit 4 set when c is a hex digit
    function automatic logic [4:0] hex_nibble(logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
            return {1'b1, c[3:0]};
        if (c >= 8'h61 && c <= 8'h66)
            t = c - 8'h61 + 8'd10;
        else if (c >= 8'h41 && c <= 8'h46)
            t = c - 8'h41 + 8'd10;
        else
            return 5'd0;
        return {1'b1, t[3:0]};
    endfunction

    function automatic void finish_escape(logic [15:0] cp);
        if (cp >= HIGH_SUR_LO && cp <= HIGH_SUR_HI)
        begin
            dec_held = cp;
            dec_mode = M_HELD;
        end
        else
        begin
            push_cp(cp);
            dec_mode = M_PLAIN;
        end
    endfunction

    // remaining hex positions are skipped
    function automatic void bad_hex();
        dec_err = ST_BAD_HEX;
        dec_skip = 3'd3 - {1'b0, dec_cnt[1:0]};
        dec_cnt = 3'd0;
        dec_mode = (dec_skip != 3'd0) ? M_SKIP_HEX : M_SKIP;
    endfunction

    function automatic void plain_char(logic [7:0] c);
        if (c == CH_QUOTE)
        begin
            push_done(dec_err);
        end
        else if (c == CH_BSLASH)
        begin
            dec_mode = M_ESC;
        end
        else
        begin
            push_byte(c);
            dec_mode = M_PLAIN;
        end
    endfunction

    function automatic void escape_char(logic [7:0] c);
        dec_mode = M_PLAIN;
        case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: push_byte(c);
            CH_B: push_byte(8'h08);
            CH_F: push_byte(8'h0C);
            CH_N: push_byte(8'h0A);
            CH_R: push_byte(8'h0D);
            CH_T: push_byte(8'h09);
            CH_U:
            begin
                dec_hex = 16'h0000;
                dec_cnt = 3'd0;
                dec_mode = M_HEX;
            end
            default:
            begin
                dec_err = ST_BAD_ESC;
                dec_letter = c;
                dec_mode = M_SKIP;
            end
        endcase
    endfunction

    function automatic void decode_byte(logic [7:0] c, logic last);
        mode_t       m;
        logic        closing;
        logic [4:0]  d;
        logic [20:0] full;
        m = dec_mode;
        dec_done = 1'b0;
        closing = (c == CH_QUOTE) && (m == M_PLAIN || m == M_SKIP || m == M_HELD);
        // end of buffer inside the string beats any earlier error
        if (last && !closing)
        begin
            push_result(8'h00, 1'b0, 1'b1, ST_BUF_END, 8'h00);
            decoder_clear();
            return;
        end
        case (m)
            M_ESC: escape_char(c);
            M_HEX, M_HELD_HEX:
            begin
                d = hex_nibble(c);
                if (!d[4])
                begin
                    if (m == M_HELD_HEX)
                        push_cp(dec_held);
                    bad_hex();
                end
                else
                begin
                    dec_hex = {dec_hex[11:0], d[3:0]};
                    dec_cnt = dec_cnt + 3'd1;
                    if (dec_cnt == 3'd4)
                    begin
                        dec_cnt = 3'd0;
                        if (m == M_HEX)
                        begin
                            finish_escape(dec_hex);
                        end
                        else if (dec_hex >= LOW_SUR_LO && dec_hex <= LOW_SUR_HI)
                        begin
                            full = SUPP_BASE + {1'b0, dec_held[9:0], dec_hex[9:0]};
                            push_byte(LEAD4 | {5'b00000, full[20:18]});
                            push_byte(CONT | {2'b00, full[17:12]});
                            push_byte(CONT | {2'b00, full[11:6]});
                            push_byte(CONT | {2'b00, full[5:0]});
                            dec_held = 16'h0000;
                            dec_mode = M_PLAIN;
                        end
                        else
                        begin
                            push_cp(dec_held);
                            dec_held = 16'h0000;
                            finish_escape(dec_hex);
                        end
                    end
                end
            end
            M_HELD:
            begin
                if (c == CH_BSLASH)
                begin
                    dec_mode = M_HELD_ESC;
                end
                else
                begin
                    push_cp(dec_held);
                    dec_held = 16'h0000;
                    plain_char(c);
                end
            end
            M_HELD_ESC:
            begin
                if (c == CH_U)
                begin
                    dec_hex = 16'h0000;
                    dec_cnt = 3'd0;
                    dec_mode = M_HELD_HEX;
                end
                else
                begin
                    push_cp(dec_held);
                    dec_held = 16'h0000;
                    escape_char(c);
                end
            end
            M_SKIP:
            begin
                if (c == CH_QUOTE)
                    push_done(dec_err);
                else if (c == CH_BSLASH)
                    dec_mode = M_SKIP_ESC;
            end
            M_SKIP_ESC:
            begin
                if (c == CH_U)
                begin
                    dec_skip = 3'd4;
                    dec_mode = M_SKIP_HEX;
                end
                else
                begin
                    dec_mode = M_SKIP;
                end
            end
            M_SKIP_HEX:
            begin
                dec_skip = (dec_skip != 3'd0) ? dec_skip - 3'd1 : 3'd0;
                if (dec_skip == 3'd0)
                    dec_mode = M_SKIP;
            end
            default: plain_char(c);
        endcase
        if (dec_done)
            decoder_clear();
    endfunction

    // string building
    function automatic void add_raw(logic [7:0] c, logic last);
        raw_t r;
        r.c = c;
        r.last = last;
        pending_q.push_back(r);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_raw(s[i], 1'b0);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        logic [7:0] base;
        base = ($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61;
        if (n < 4'd10)
            return 8'h30 + {4'h0, n};
        return base + {4'h0, n} - 8'd10;
    endfunction

    function automatic void add_u(logic [15:0] v);
        add_raw(CH_BSLASH, 1'b0);
        add_raw(CH_U, 1'b0);
        for (int i = 3; i >= 0; i--)
            add_raw(hex_char(v[4 * i +: 4]), 1'b0);
    endfunction

    // one transaction on the input channel, bursts separated by random gaps
    task automatic send_item(logic [7:0] c, logic last);
        int gap;
        if (send_gaps && burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
            if (gap != 0)
            begin
                @(negedge clk);
                item_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        item_ch.valid <= 1'b1;
        item_ch.in_byte <= c;
        item_ch.buffer_end <= last;
        do @(posedge clk); while (!item_ch.ready);
        decode_byte(c, last);
    endtask

    task automatic send_pending();
        raw_t r;
        while (pending_q.size() != 0)
        begin
            r = pending_q.pop_front();
            send_item(r.c, r.last);
            sent_count++;
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    // receiver: always ready, or runs of ready and stall, plus requested hold-offs
    initial
    begin : receiver
        int   run;
        int   hold;
        logic lvl;
        res_ch.ready = 1'b0;
        run = 0;
        hold = 0;
        lvl = 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                hold = hold_req;
                hold_req = 0;
            end
            if (hold > 0)
            begin
                hold--;
                res_ch.ready <= 1'b0;
            end
            else if (!rx_stalls)
            begin
                res_ch.ready <= 1'b1;
            end
            else
            begin
                if (run == 0)
                begin
                    lvl = ($urandom_range(0, 3) != 0);
                    run = lvl ? $urandom_range(1, 10) : $urandom_range(1, 6);
                end
                run--;
                res_ch.ready <= lvl;
            end
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result transaction with nothing expected: out_byte %0h status %0d",
                       res_ch.out_byte, res_ch.status);
                n_errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("out_byte", want.out_byte, res_ch.out_byte);
                check_field("byte_valid", {7'd0, want.byte_valid},
                            {7'd0, res_ch.byte_valid});
                check_field("string_done", {7'd0, want.string_done},
                            {7'd0, res_ch.string_done});
                check_field("status", {6'd0, want.status}, {6'd0, res_ch.status});
                check_field("bad_char", want.bad_char, res_ch.bad_char);
            end
        end
    end

    task automatic test_simple_escapes();
        add_raw(8'h00, 1'b0);
        add_raw(8'hFF, 1'b0);
        add_text("\\\"\\\\\\/\\b\\f\\n\\r\\t\"");
        send_pending();
        wait_drained();
    endtask

    task automatic test_unicode();
        add_text("\\u07FF\\uffff\\uD83D\\uDE00\\u0041\"");
        // broken pairs, lone low half, held high half at the closing quote
        add_text("\\uDBFF\\uD800\\uDC00\\uDFFFx\\uD800\\u0800\\uD800\"");
        send_pending();
        wait_drained();
    endtask

    task automatic test_errors();
        // quotes in skipped hex positions do not end the string
        add_text("ab\\qz\\u\"\"\"\"x\"");
        add_text("\\u12\"4\"");
        add_text("\\uD800\\u00Z\"\"");
        add_text("\\uD800\\k\"");
        add_text("\\uD800\\n\"");
        add_raw(CH_BSLASH, 1'b0);
        add_raw(8'hFF, 1'b0);
        add_text("\"");
        send_pending();
        wait_drained();
    endtask

    task automatic test_buffer_end();
        add_text("a");
        add_raw(8'h62, 1'b1);
        add_text("\\q");
        add_raw(8'h78, 1'b1);
        add_raw(CH_QUOTE, 1'b1);
        add_text("\\u12");
        add_raw(8'h33, 1'b1);
        add_text("\\uD800");
        add_raw(CH_QUOTE, 1'b1);
        add_text("\\u");
        add_raw(CH_QUOTE, 1'b1);
        send_pending();
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_gaps = 1'b0;
        rx_stalls = 1'b0;
        hold_req = HOLD_OFF_CYCLES;
        repeat (4) add_text("\\uD800\\u0800");
        add_text("abc\"");
        send_pending();
        wait_drained();
    endtask

    task automatic test_random_strings();
        int         n_tok;
        int         k;
        logic [7:0] c;
        logic [4:0] d;
        raw_t       r;
        sent_count = 0;
        while (sent_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                send_gaps = ($urandom_range(0, 2) != 0);
                rx_stalls = ($urandom_range(0, 2) != 0);
            end
            if ($urandom_range(0, 7) == 0)
            begin
                // noise rich in the bytes that steer the decoder
                repeat ($urandom_range(1, 8))
                begin
                    case ($urandom_range(0, 4))
                        0: c = CH_QUOTE;
                        1: c = CH_BSLASH;
                        2: c = CH_U;
                        3: c = hex_char(4'($urandom_range(0, 15)));
                        default: c = 8'($urandom_range(0, 255));
                    endcase
                    add_raw(c, $urandom_range(0, 15) == 0);
                end
            end
            else
            begin
                n_tok = $urandom_range(1, 5);
                repeat (n_tok)
                begin
                    case ($urandom_range(0, 11))
                        0, 1, 2:
                        begin
                            c = 8'($urandom_range(0, 255));
                            if (c == CH_QUOTE || c == CH_BSLASH)
                                c = c ^ 8'h01;
                            add_raw(c, 1'b0);
                        end
                        3:
                        begin
                            case ($urandom_range(0, 7))
                                0: c = CH_QUOTE;
                                1: c = CH_BSLASH;
                                2: c = CH_SLASH;
                                3: c = CH_B;
                                4: c = CH_F;
                                5: c = CH_N;
                                6: c = CH_R;
                                default: c = CH_T;
                            endcase
                            add_raw(CH_BSLASH, 1'b0);
                            add_raw(c, 1'b0);
                        end
                        4: add_u(16'($urandom_range(0, 16'h007F)));
                        5: add_u(16'($urandom_range(16'h0080, 16'h07FF)));
                        6: add_u(16'($urandom_range(16'h0800, 16'hFFFF)));
                        7:
                        begin
                            add_u(16'($urandom_range(HIGH_SUR_LO, HIGH_SUR_HI)));
                            add_u(16'($urandom_range(LOW_SUR_LO, LOW_SUR_HI)));
                        end
                        8: add_u(16'($urandom_range(HIGH_SUR_LO, LOW_SUR_HI)));
                        9:
                        begin
                            c = 8'($urandom_range(0, 255));
                            if (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_B ||
                                c == CH_F || c == CH_N || c == CH_R || c == CH_T || c == CH_U)
                                c = c | 8'h80;
                            add_raw(CH_BSLASH, 1'b0);
                            add_raw(c, 1'b0);
                        end
                        10:
                        begin
                            if ($urandom_range(0, 1) != 0)
                                add_u(16'($urandom_range(HIGH_SUR_LO, HIGH_SUR_HI)));
                            add_raw(CH_BSLASH, 1'b0);
                            add_raw(CH_U, 1'b0);
                            k = $urandom_range(0, 3);
                            repeat (k) add_raw(hex_char(4'($urandom_range(0, 15))), 1'b0);
                            c = 8'($urandom_range(0, 255));
                            d = hex_nibble(c);
                            if (d[4])
                                c = CH_QUOTE;
                            add_raw(c, 1'b0);
                        end
                        default:
                        begin
                            add_u(16'($urandom_range(HIGH_SUR_LO, HIGH_SUR_HI)));
                            add_u(16'($urandom_range(0, 16'hFFFF)));
                        end
                    endcase
                end
                case ($urandom_range(0, 15))
                    0:
                    begin
                        r = pending_q.pop_back();
                        r.last = 1'b1;
                        pending_q.push_back(r);
                    end
                    1: add_raw(CH_QUOTE, 1'b1);
                    default: add_raw(CH_QUOTE, 1'b0);
                endcase
            end
            send_pending();
        end
    endtask

    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.in_byte = 8'h00;
        item_ch.buffer_end = 1'b0;
        decoder_clear();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_simple_escapes();
        test_unicode();
        test_errors();
        test_buffer_end();
        test_backpressure();
        test_random_strings();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0 && expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
rtl/jsu_pkg.sv
rtl/jsu_in_if.sv
rtl/jsu_out_if.sv
rtl/json_string_unescape_utf8_top.sv
bench/json_string_unescape_utf8_top_tb.sv
